/* rtl/adc_scan_ascii_reporter_unit_assert.svh */
// Assertion macros shared by the ADC scan reporter RTL.
// Needs no package; define NO_ASSERTIONS to compile every use to nothing.
`ifndef ADC_SCAN_ASCII_REPORTER_UNIT_ASSERT_SVH
`define ADC_SCAN_ASCII_REPORTER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked while reset is released.
`define ASAR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("asar assertion failed");
// Checked on every edge, reset included.
`define ASAR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("asar assertion failed");
`else
`define ASAR_ASSERT(lbl, clk, rstn, prop)
`define ASAR_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* rtl/asar_pkg.sv */
// Package for the ADC scan ASCII reporter: codes, characters, microcode types
// and the control store. No dependencies.
`default_nettype none

package asar_pkg;

    localparam int NUM_SLOTS   = 3;
    localparam int SAMPLE_W    = 10;
    localparam int SLOT_W      = 2;
    localparam int PC_W        = 3;
    localparam int CHAR_W      = 8;
    localparam int IN_TDATA_W  = 16;

    // Input item kinds carried on the slave tuser.
    localparam logic OPC_CONV = 1'b0;
    localparam logic OPC_TICK = 1'b1;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    typedef enum logic {
        OP_DIGIT,
        OP_CHAR
    } t_uop_op;

    typedef enum logic [1:0] {
        PL_1000,
        PL_100,
        PL_10,
        PL_1
    } t_place;

    typedef enum logic [1:0] {
        JC_NONE,
        JC_ALWAYS,
        JC_LAST_SLOT
    } t_jcond;

    typedef struct packed {
        t_uop_op           op;
        t_place            place;
        logic              load;
        logic [CHAR_W-1:0] chr;
        logic              last;
        logic              fin;
        t_jcond            jc;
        logic [PC_W-1:0]   target;
        logic              inc_slot;
    } t_uop;

    // Control handed from the sequencer to the datapath for one step.
    typedef struct packed {
        logic              exec;
        t_uop_op           op;
        t_place            place;
        logic              load;
        logic [SLOT_W-1:0] slot;
        logic [CHAR_W-1:0] chr;
        logic              last;
    } t_dp_ctl;

    localparam logic [PC_W-1:0] PC_NUM   = 3'd0;
    localparam logic [PC_W-1:0] PC_TAIL  = 3'd6;

    // Program: four digits of the current slot, then either comma-space and
    // back to the next slot, or LF, CR and halt after the last slot.
    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        u = '{op: OP_CHAR, place: PL_1, load: 1'b0, chr: CH_SPACE, last: 1'b0,
              fin: 1'b0, jc: JC_NONE, target: PC_NUM, inc_slot: 1'b0};
        case (pc)
            3'd0: begin
                u.op    = OP_DIGIT;
                u.place = PL_1000;
                u.load  = 1'b1;
            end
            3'd1: begin
                u.op    = OP_DIGIT;
                u.place = PL_100;
            end
            3'd2: begin
                u.op    = OP_DIGIT;
                u.place = PL_10;
            end
            3'd3: begin
                u.op     = OP_DIGIT;
                u.place  = PL_1;
                u.jc     = JC_LAST_SLOT;
                u.target = PC_TAIL;
            end
            3'd4: begin
                u.chr = CH_COMMA;
            end
            3'd5: begin
                u.chr      = CH_SPACE;
                u.jc       = JC_ALWAYS;
                u.target   = PC_NUM;
                u.inc_slot = 1'b1;
            end
            3'd6: begin
                u.chr = CH_LF;
            end
            3'd7: begin
                u.chr  = CH_CR;
                u.last = 1'b1;
                u.fin  = 1'b1;
            end
            default: begin
                u.fin = 1'b1;
            end
        endcase
        return u;
    endfunction

    function automatic logic [SAMPLE_W-1:0] place_value(input t_place p);
        logic [SAMPLE_W-1:0] r;
        case (p)
            PL_1000: r = 10'd1000;
            PL_100:  r = 10'd100;
            PL_10:   r = 10'd10;
            PL_1:    r = 10'd1;
            default: r = 10'd1;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/asar_seq.sv */
// Microcode sequencer: step counter, slot counter and conditional jumps
// over the control store in asar_pkg. Depends on asar_pkg and the assert header.
`default_nettype none
`include "adc_scan_ascii_reporter_unit_assert.svh"

module asar_seq
    import asar_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire logic    i_out_free,
    output t_dp_ctl      o_ctl,
    output logic         o_ready
);

    logic              r_busy;
    logic              n_busy;
    logic [PC_W-1:0]   r_pc;
    logic [PC_W-1:0]   n_pc;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    t_uop              w_uop;
    logic              w_adv;
    logic              w_jump;

    assign w_uop = uop_rom(r_pc);
    assign w_adv = r_busy && i_out_free;

    always_comb begin
        case (w_uop.jc)
            JC_NONE:      w_jump = 1'b0;
            JC_ALWAYS:    w_jump = 1'b1;
            JC_LAST_SLOT: w_jump = (r_slot == LAST_SLOT);
            default:      w_jump = 1'b0;
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        n_slot = r_slot;
        if (i_start) begin
            n_busy = 1'b1;
            n_pc   = PC_NUM;
            n_slot = '0;
        end else if (w_adv) begin
            if (w_uop.fin) begin
                n_busy = 1'b0;
                n_pc   = PC_NUM;
            end else if (w_jump) begin
                n_pc = w_uop.target;
            end else begin
                n_pc = r_pc + PC_W'(1);
            end
            if (w_uop.inc_slot) begin
                n_slot = r_slot + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= PC_NUM;
            r_slot <= '0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
            r_slot <= n_slot;
        end
    end

    // A new transaction may enter on the cycle that issues the final step.
    assign o_ready = !r_busy || (w_adv && w_uop.fin);

    always_comb begin
        o_ctl.exec  = w_adv;
        o_ctl.op    = w_uop.op;
        o_ctl.place = w_uop.place;
        o_ctl.load  = w_uop.load;
        o_ctl.slot  = r_slot;
        o_ctl.chr   = w_uop.chr;
        o_ctl.last  = w_uop.last;
    end

    `ASAR_ASSERT(a_slot_in_range, i_clk, i_rst_n, r_busy |-> (r_slot != 2'd3))
    `ASAR_ASSERT(a_cr_after_last_slot, i_clk, i_rst_n, (w_adv && w_uop.last) |-> (r_slot == LAST_SLOT))
    `ASAR_ASSERT(a_halt_after_fin, i_clk, i_rst_n, (w_adv && w_uop.fin && !i_start) |=> !r_busy)
    `ASAR_ASSERT(a_start_only_ready, i_clk, i_rst_n, i_start |-> o_ready)

endmodule

`default_nettype wire

/* rtl/asar_dp.sv */
// Datapath: sample slots, channel pointer, one decimal digit per step and
// the output register. Depends on asar_pkg.
`default_nettype none

module asar_dp
    import asar_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_conv,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire t_dp_ctl             i_ctl,
    input  wire logic                i_out_ready,
    output logic                     o_out_free,
    output logic                     o_out_valid,
    output logic [CHAR_W-1:0]        o_out_byte,
    output logic                     o_out_last
);

    logic [SAMPLE_W-1:0] r_slots [NUM_SLOTS];
    logic [SLOT_W-1:0]   r_chan;
    logic [SAMPLE_W-1:0] r_rem;
    logic [SAMPLE_W-1:0] n_rem;
    logic                r_lead;
    logic                n_lead;
    logic                r_valid;
    logic [CHAR_W-1:0]   r_byte;
    logic                r_last;
    logic [CHAR_W-1:0]   n_byte;

    logic [SAMPLE_W-1:0] w_opnd;
    logic                w_lead;
    logic [3:0]          w_q;
    logic [15:0]         w_prod100;
    logic [14:0]         w_prod10;
    logic [13:0]         w_qp;

    // Conversion transactions fill slots round robin over three channels.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_slots[i] <= '0;
            end
        end else if (i_conv) begin
            case (r_chan)
                2'd0: begin
                    r_slots[0] <= i_sample;
                    r_chan     <= 2'd1;
                end
                2'd1: begin
                    r_slots[1] <= i_sample;
                    r_chan     <= 2'd2;
                end
                2'd2: begin
                    r_slots[2] <= i_sample;
                    r_chan     <= 2'd0;
                end
                default: begin
                    r_chan <= 2'd0;
                end
            endcase
        end
    end

    assign w_opnd    = i_ctl.load ? r_slots[i_ctl.slot] : r_rem;
    assign w_lead    = i_ctl.load ? 1'b1 : r_lead;
    assign w_prod100 = {6'd0, w_opnd} * 16'd41;
    assign w_prod10  = {8'd0, w_opnd[6:0]} * 15'd205;

    // Reciprocal multiplies are exact over the ranges each place can see.
    always_comb begin
        case (i_ctl.place)
            PL_1000: w_q = (w_opnd >= 10'd1000) ? 4'd1 : 4'd0;
            PL_100:  w_q = w_prod100[15:12];
            PL_10:   w_q = w_prod10[14:11];
            PL_1:    w_q = w_opnd[3:0];
            default: w_q = 4'd0;
        endcase
    end

    assign w_qp  = w_q * place_value(i_ctl.place);
    assign n_rem = w_opnd - w_qp[SAMPLE_W-1:0];

    always_comb begin
        n_lead = r_lead;
        n_byte = i_ctl.chr;
        if (i_ctl.op == OP_DIGIT) begin
            n_lead = w_lead && (w_q == 4'd0);
            if (n_lead && (i_ctl.place != PL_1)) begin
                n_byte = CH_SPACE;
            end else begin
                n_byte = CH_ZERO + {4'd0, w_q};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec && (i_ctl.op == OP_DIGIT)) begin
            r_rem  <= n_rem;
            r_lead <= n_lead;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.exec) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_byte <= n_byte;
            r_last <= i_ctl.last;
        end
    end

    assign o_out_free  = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out_byte  = r_byte;
    assign o_out_last  = r_last;

endmodule

`default_nettype wire

/* rtl/adc_scan_ascii_reporter_unit.sv */
// Report tick: 18 output bytes, one per cycle while the sink keeps up; after the tick
// is accepted the sequencer goes busy, then registers each byte in the output register.
// The next tick can enter on the cycle of the final CR step; one byte per microcode step.
// A conversion transaction waits while a line is in progress.
// Synchronous active-low reset zeroes the slots and channel pointer, idles the sequencer.
// Top level of the ADC scan ASCII reporter; depends on asar_pkg, asar_seq, asar_dp.
`default_nettype none

module adc_scan_ascii_reporter_unit
    import asar_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,  // [9:0] sample, rest zero
    input  wire logic                  s_axis_tuser,  // [0] opcode: 0 conversion, 1 tick
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [CHAR_W-1:0]          m_axis_tdata,  // [7:0] text_byte
    output logic                       m_axis_tlast
);

    logic    w_acc;
    logic    w_start;
    logic    w_conv;
    logic    w_out_free;
    t_dp_ctl w_ctl;

    assign w_acc   = s_axis_tvalid && s_axis_tready;
    assign w_start = w_acc && (s_axis_tuser == OPC_TICK);
    assign w_conv  = w_acc && (s_axis_tuser == OPC_CONV);

    asar_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_out_free (w_out_free),
        .o_ctl      (w_ctl),
        .o_ready    (s_axis_tready)
    );

    asar_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_conv      (w_conv),
        .i_sample    (s_axis_tdata[SAMPLE_W-1:0]),
        .i_ctl       (w_ctl),
        .i_out_ready (m_axis_tready),
        .o_out_free  (w_out_free),
        .o_out_valid (m_axis_tvalid),
        .o_out_byte  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire
